@@ hdl/rvdf_pkg.sv @@
// ----------------------------------------------------------------------------
// rvdf_pkg: shared types and constants of the recent vertex duplicate filter
// Command codes, port widths and the controller/datapath signal groups.
// ----------------------------------------------------------------------------
package rvdf_pkg;

  localparam int CMD_W = 2;
  localparam int ID_W  = 32;

  localparam logic [CMD_W-1:0] CMD_FILTER      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN_LEVEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BEGIN_FIRST = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END_LEVEL   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;       // take the id and read its set
    logic ptr_reset;     // round-robin way pointer back to zero
    logic clear_start;   // restart the clearing pass at set zero
    logic clear_write;   // write one all-ones row of the clearing pass
    logic lookup_write;  // write the missed tag into the victim way
    logic load_id;       // load the passed id into the result register
    logic load_done;     // load the end-of-level marker
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic clear_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

@@ hdl/rvdf_in_if.sv @@
// ----------------------------------------------------------------------------
// rvdf_in_if: request channel of the duplicate filter
// Valid/ready handshake carrying a command and a vertex id.
// ----------------------------------------------------------------------------
interface rvdf_in_if;
  import rvdf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0]  vertex_id;

  modport source (output valid, output command, output vertex_id, input ready);
  modport sink   (input valid, input command, input vertex_id, output ready);
endinterface

@@ hdl/rvdf_out_if.sv @@
// ----------------------------------------------------------------------------
// rvdf_out_if: result channel of the duplicate filter
// Valid/ready handshake carrying a passed id or an end-of-level marker.
// ----------------------------------------------------------------------------
interface rvdf_out_if;
  import rvdf_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] vertex_out;
  logic            level_done;

  modport source (output valid, output vertex_out, output level_done, input ready);
  modport sink   (input valid, input vertex_out, input level_done, output ready);
endinterface

@@ hdl/rvdf_ram.sv @@
// ----------------------------------------------------------------------------
// rvdf_ram: generic single-port RAM
// One write or one read per cycle, read data registered and held.
// ----------------------------------------------------------------------------
module rvdf_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hdl/rvdf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rvdf_ctrl: controller of the duplicate filter
// Sequences requests, lookups, result loads and the clearing pass.
// ----------------------------------------------------------------------------
module rvdf_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [rvdf_pkg::CMD_W-1:0] command,
  output logic                     in_ready,
  input  rvdf_pkg::ctrl_stat_t     stat,
  output rvdf_pkg::ctrl_cmd_t      cmd
);
  import rvdf_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (fire) begin
          case (command)
            CMD_FILTER: begin
              cmd.capture = 1'b1;
              state_next  = S_LOOK;
            end
            CMD_BEGIN_LEVEL: begin
              cmd.ptr_reset = 1'b1;
            end
            CMD_BEGIN_FIRST: begin
              cmd.ptr_reset   = 1'b1;
              cmd.clear_start = 1'b1;
              state_next      = S_CLEAR;
            end
            CMD_END_LEVEL: begin
              state_next = S_DONE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_LOOK: begin
        // A hit drops the id; a miss waits for a free result register.
        if (stat.hit) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.lookup_write = 1'b1;
          cmd.load_id      = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/rvdf_datapath.sv @@
// ----------------------------------------------------------------------------
// rvdf_datapath: tag store and result register of the duplicate filter
// Set/tag split, way compare, victim pointer, clearing counter, output slot.
// ----------------------------------------------------------------------------
module rvdf_datapath #(
  parameter int INDEX_BITS = 14,
  parameter int NUM_WAYS   = 4,
  parameter int ID_BITS    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rvdf_pkg::ID_W-1:0] vertex_id,
  input  rvdf_pkg::ctrl_cmd_t       cmd,
  output rvdf_pkg::ctrl_stat_t      stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rvdf_pkg::ID_W-1:0] vertex_out,
  output logic                      level_done
);
  import rvdf_pkg::*;

  localparam int TAG_BITS = (ID_BITS > INDEX_BITS) ? (ID_BITS - INDEX_BITS) : 0;
  localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int ROW_W    = NUM_WAYS * TAG_W;
  localparam int SETS     = 2 ** INDEX_BITS;
  localparam int PTR_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  // With no tag bits every stored and looked-up tag is zero.
  localparam logic [TAG_W-1:0] CLEAR_TAG = (TAG_BITS > 0) ? {TAG_W{1'b1}} : {TAG_W{1'b0}};

  logic [ID_BITS-1:0]    id_in;
  logic [ID_BITS-1:0]    id_q;
  logic [INDEX_BITS-1:0] set_in;
  logic [INDEX_BITS-1:0] set_q;
  logic [TAG_W-1:0]      tag_q;
  logic [INDEX_BITS-1:0] clr_cnt;
  logic [PTR_W-1:0]      ptr;
  logic [ROW_W-1:0]      row_rd;
  logic [ROW_W-1:0]      row_wr;
  logic [INDEX_BITS-1:0] ram_addr;
  logic                  hit;

  assign id_in = vertex_id[ID_BITS-1:0];

  generate
    if (INDEX_BITS <= ID_BITS) begin : g_set_narrow
      assign set_in = id_in[INDEX_BITS-1:0];
      assign set_q  = id_q[INDEX_BITS-1:0];
    end else begin : g_set_wide
      assign set_in = INDEX_BITS'(id_in);
      assign set_q  = INDEX_BITS'(id_q);
    end
    if (TAG_BITS > 0) begin : g_tag
      assign tag_q = id_q[ID_BITS-1:ID_BITS-TAG_W];
    end else begin : g_no_tag
      assign tag_q = '0;
    end
  endgenerate

  always_comb begin
    hit    = 1'b0;
    row_wr = row_rd;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row_rd[w*TAG_W +: TAG_W] == tag_q) begin
        hit = 1'b1;
      end
      if (PTR_W'(w) == ptr) begin
        row_wr[w*TAG_W +: TAG_W] = tag_q;
      end
    end
    if (cmd.clear_write) begin
      row_wr = {NUM_WAYS{CLEAR_TAG}};
    end
  end

  always_comb begin
    if (cmd.clear_write) begin
      ram_addr = clr_cnt;
    end else if (cmd.capture) begin
      ram_addr = set_in;
    end else begin
      ram_addr = set_q;
    end
  end

  rvdf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tags (
    .clk   (clk),
    .we    (cmd.clear_write | cmd.lookup_write),
    .re    (cmd.capture),
    .addr  (ram_addr),
    .wdata (row_wr),
    .rdata (row_rd)
  );

  assign stat.hit        = hit;
  assign stat.clear_last = (clr_cnt == {INDEX_BITS{1'b1}});
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_q <= id_in;
    end
    if (cmd.load_id) begin
      vertex_out <= ID_W'(id_q);
      level_done <= 1'b0;
    end else if (cmd.load_done) begin
      vertex_out <= '0;
      level_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_start) begin
        clr_cnt <= '0;
      end else if (cmd.clear_write) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.ptr_reset) begin
        ptr <= '0;
      end else if (cmd.lookup_write) begin
        ptr <= (ptr == PTR_W'(NUM_WAYS - 1)) ? '0 : ptr + 1'b1;
      end
      if (cmd.load_id || cmd.load_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/recent_vertex_duplicate_filter_unit.sv @@
// ----------------------------------------------------------------------------
// recent_vertex_duplicate_filter_unit: top level of the duplicate filter
// Drops vertex ids whose tag is found in one of the ways of their set.
// ----------------------------------------------------------------------------
// A filter request reads its set from the single-port tag RAM at acceptance,
// compares in the next cycle and, on a miss, writes back once the result
// register is free, so filter and end-level requests hold off the next request
// until done; begin level is accepted every cycle. A result is registered;
// while it waits, the next result stalls. After reset and a begin-first-level
// request, a clearing pass writes every set to all ones; no request is taken then.
module recent_vertex_duplicate_filter_unit #(
  parameter int INDEX_BITS = 14,
  parameter int NUM_WAYS   = 4,
  parameter int ID_BITS    = 32
) (
  input logic        clk,
  input logic        rst,
  rvdf_in_if.sink    request,
  rvdf_out_if.source result
);
  import rvdf_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  rvdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .command  (request.command),
    .in_ready (request.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rvdf_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .NUM_WAYS   (NUM_WAYS),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .vertex_id  (request.vertex_id),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .vertex_out (result.vertex_out),
    .level_done (result.level_done)
  );

endmodule

@@ bench/rvdf_pass_checker.sv @@
// ----------------------------------------------------------------------------
// rvdf_pass_checker: result checker for the recent vertex duplicate filter
// Watches both channels and keeps its own copy of the way tags and the
// round-robin pointer. From every accepted request it predicts the id or
// end-of-level marker that should come out, and compares each accepted
// result in order against that prediction.
// ----------------------------------------------------------------------------
module rvdf_pass_checker #(
  parameter int INDEX_BITS = 14,
  parameter int NUM_WAYS   = 4,
  parameter int ID_BITS    = 32
) (
  input  logic clk,
  input  logic rst,
  rvdf_in_if   request,
  rvdf_out_if  result,
  output int   failures,
  output int   outstanding
);
  import rvdf_pkg::*;

  localparam int TAG_W = ID_BITS - INDEX_BITS;
  localparam int SETS  = 1 << INDEX_BITS;
  localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_BITS);

  typedef struct {
    logic [ID_W-1:0] vertex_out;
    logic            level_done;
  } filter_result_t;

  logic [TAG_W-1:0] way_tag [NUM_WAYS][SETS];
  int               victim_ptr = 0;
  int               mismatches = 0;
  filter_result_t   predicted_q [$];

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  function automatic void clear_tags();
    for (int w = 0; w < NUM_WAYS; w++) begin
      for (int s = 0; s < SETS; s++) begin
        way_tag[w][s] = '1;
      end
    end
  endfunction

  function automatic void predict_filter(input logic [CMD_W-1:0] cmd,
                                         input logic [ID_W-1:0] raw_id);
    logic [ID_W-1:0]       id;
    logic [INDEX_BITS-1:0] set_idx;
    logic [TAG_W-1:0]      tag;
    bit                    hit;
    filter_result_t        res;
    id      = raw_id & ID_MASK;
    set_idx = id[INDEX_BITS-1:0];
    tag     = TAG_W'(id >> INDEX_BITS);
    hit     = 1'b0;
    case (cmd)
      CMD_BEGIN_LEVEL: begin
        victim_ptr = 0;
      end
      CMD_BEGIN_FIRST: begin
        victim_ptr = 0;
        clear_tags();
      end
      CMD_END_LEVEL: begin
        res.vertex_out = '0;
        res.level_done = 1'b1;
        predicted_q.push_back(res);
      end
      CMD_FILTER: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (way_tag[w][set_idx] == tag) hit = 1'b1;
        end
        // A miss takes the victim way and moves the pointer on; a hit is dropped.
        if (!hit) begin
          way_tag[victim_ptr][set_idx] = tag;
          victim_ptr = (victim_ptr + 1 >= NUM_WAYS) ? 0 : victim_ptr + 1;
          res.vertex_out = id;
          res.level_done = 1'b0;
          predicted_q.push_back(res);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    filter_result_t want;
    if (rst) begin
      clear_tags();
      victim_ptr = 0;
      predicted_q.delete();
    end else begin
      // A result never leaves in the cycle its request is accepted, so retire before predicting.
      if (result.valid && result.ready) begin
        if (predicted_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual vertex_out=%h level_done=%b",
                   $time, result.vertex_out, result.level_done);
        end else begin
          want = predicted_q.pop_front();
          if (want.vertex_out !== result.vertex_out) begin
            mismatches++;
            $display("%0t: vertex_out mismatch, expected %h actual %h",
                     $time, want.vertex_out, result.vertex_out);
          end
          if (want.level_done !== result.level_done) begin
            mismatches++;
            $display("%0t: level_done mismatch, expected %b actual %b",
                     $time, want.level_done, result.level_done);
          end
        end
      end
      if (request.valid && request.ready) begin
        predict_filter(request.command, request.vertex_id);
      end
    end
    failures    <= mismatches;
    outstanding <= predicted_q.size();
  end

endmodule

@@ bench/recent_vertex_duplicate_filter_unit_test.sv @@
// ----------------------------------------------------------------------------
// recent_vertex_duplicate_filter_unit_test: testbench of the duplicate filter
// Sends a directed set of requests around hits, evictions, all-ones tags and
// the level commands, then random levels of ids drawn mostly from a few
// crowded sets, with random gaps on both channels and a checker beside it.
// ----------------------------------------------------------------------------
module recent_vertex_duplicate_filter_unit_test;
  import rvdf_pkg::*;

  localparam int INDEX_BITS        = 14;
  localparam int NUM_WAYS          = 4;
  localparam int ID_BITS           = 32;
  localparam int TAG_W             = ID_BITS - INDEX_BITS;
  localparam int REQUEST_TARGET    = 750;
  localparam int MAX_RANDOM_CLEARS = 6;
  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int TAIL_CYCLES       = 20;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   cycle_count;
  int   sent;
  bit   steady;

  rvdf_in_if  request_ch ();
  rvdf_out_if result_ch ();

  recent_vertex_duplicate_filter_unit #(
    .INDEX_BITS (INDEX_BITS),
    .NUM_WAYS   (NUM_WAYS),
    .ID_BITS    (ID_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  rvdf_pass_checker #(
    .INDEX_BITS (INDEX_BITS),
    .NUM_WAYS   (NUM_WAYS),
    .ID_BITS    (ID_BITS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .request     (request_ch),
    .result      (result_ch),
    .failures    (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial result_ch.ready = 1'b0;

  always @(posedge clk) begin
    result_ch.ready <= !rst && (steady || $urandom_range(99) >= 16);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    int gap;
    if (!steady && $urandom_range(99) < 16) begin
      gap = $urandom_range(1, 4);
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid     <= 1'b1;
    request_ch.command   <= cmd;
    request_ch.vertex_id <= id;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    sent++;
    steady = (sent >= 300 && sent < 450);
  endtask

  task automatic drain_results();
    request_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Most ids land in a handful of sets with few tags, so hits and evictions
  // are frequent; the rest are fully random.
  function automatic logic [ID_W-1:0] crowded_id();
    logic [TAG_W-1:0]      tag;
    logic [INDEX_BITS-1:0] set_idx;
    case ($urandom_range(0, 3))
      0:       set_idx = '0;
      1:       set_idx = '1;
      default: set_idx = INDEX_BITS'($urandom_range(1, 6));
    endcase
    tag = TAG_W'($urandom_range(0, 6));
    if (tag == TAG_W'(6)) tag = '1;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      9:       return {tag | '1, set_idx};
      default: return {tag, set_idx};
    endcase
  endfunction

  initial begin
    int               level_len;
    int               clears;
    bit               paused;
    logic [CMD_W-1:0] noise_cmd;
    rst                  = 1'b1;
    request_ch.valid     = 1'b0;
    request_ch.command   = CMD_FILTER;
    request_ch.vertex_id = '0;
    sent                 = 0;
    steady               = 1'b0;
    clears               = 0;
    paused               = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Fresh store: an all-ones tag hits without ever being written.
    send_request(CMD_FILTER, 32'h0000_0000);
    send_request(CMD_FILTER, 32'h0000_0000);
    send_request(CMD_FILTER, 32'hFFFF_FFFF);
    send_request(CMD_FILTER, 32'hFFFF_C000);
    send_request(CMD_FILTER, 32'h0000_3FFF);
    send_request(CMD_END_LEVEL, 32'hFFFF_FFFF);
    // Begin level keeps the store; fill all ways of set zero and evict.
    send_request(CMD_BEGIN_LEVEL, 32'h1234_5678);
    send_request(CMD_FILTER, {18'd1, 14'd0});
    send_request(CMD_FILTER, {18'd2, 14'd0});
    send_request(CMD_FILTER, {18'd3, 14'd0});
    send_request(CMD_FILTER, {18'd4, 14'd0});
    send_request(CMD_FILTER, 32'h0000_0000);
    send_request(CMD_FILTER, {18'd2, 14'd0});
    send_request(CMD_FILTER, 32'hFFFF_FFFF);
    send_request(CMD_FILTER, 32'hAAAA_5555);
    send_request(CMD_END_LEVEL, 32'h0000_0000);
    send_request(CMD_BEGIN_FIRST, 32'h0000_0000);
    send_request(CMD_FILTER, 32'h0000_0000);
    send_request(CMD_FILTER, 32'hFFFF_FFFF);
    send_request(CMD_FILTER, 32'h5555_AAAA);
    send_request(CMD_END_LEVEL, 32'h0000_0000);
    drain_results();

    while (sent < REQUEST_TARGET) begin
      if ($urandom_range(0, 7) == 0 && clears < MAX_RANDOM_CLEARS) begin
        clears++;
        send_request(CMD_BEGIN_FIRST, $urandom());
      end else if ($urandom_range(0, 9) != 0) begin
        send_request(CMD_BEGIN_LEVEL, $urandom());
      end
      level_len = $urandom_range(4, 40);
      repeat (level_len) begin
        if ($urandom_range(0, 19) == 0) begin
          noise_cmd = CMD_W'($urandom_range(0, 3));
          // Every clearing pass is long, so stray clears share the same budget.
          if (noise_cmd == CMD_BEGIN_FIRST) begin
            if (clears < MAX_RANDOM_CLEARS) begin
              clears++;
            end else begin
              noise_cmd = CMD_BEGIN_LEVEL;
            end
          end
          send_request(noise_cmd, $urandom());
        end else begin
          send_request(CMD_FILTER, crowded_id());
        end
      end
      if ($urandom_range(0, 9) != 0) send_request(CMD_END_LEVEL, $urandom());
      if (!paused && sent >= 200) begin
        paused = 1'b1;
        drain_results();
      end
    end

    request_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
